[sv/ptra_pkg.sv]
package ptra_pkg;

    // Default number of per-task records.
    localparam int NUM_TASKS_DEF = 16;

    // Field widths of the stream items and the configuration register.
    localparam int TASK_W  = 4;
    localparam int WORD_W  = 32;
    localparam int WIDE_W  = 64;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 288;

    // Saturation limit of the longest burst.
    localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

    // Operation codes carried in tuser.
    localparam logic OP_SWITCH = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Input tdata layout.
    localparam int IN_RAW_LSB   = 0;
    localparam int IN_OV_BIT    = 32;
    localparam int IN_OT_LSB    = 33;
    localparam int IN_IV_BIT    = 37;
    localparam int IN_IT_LSB    = 38;

    // Output tdata layout.
    localparam int OUT_NOW_LSB   = 0;
    localparam int OUT_TOTAL_LSB = 64;
    localparam int OUT_LONG_LSB  = 128;
    localparam int OUT_ENTRY_LSB = 160;
    localparam int OUT_IDLE_LSB  = 192;
    localparam int OUT_SWTCH_LSB = 256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the request and read the outgoing task's record
        logic delta;    // form the run time, read the incoming task's entry count
        logic commit;   // write back and load the result register
    } t_cmd;

endpackage

[sv/ptra_ctrl.sv]
module ptra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ptra_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DELTA  = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       accept;
    logic       commit;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign commit = (r_state == ST_COMMIT) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_DELTA;
            ST_DELTA:  n_state = ST_COMMIT;
            ST_COMMIT: if (commit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        priority if (commit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_cmd.accept = accept;
    assign o_cmd.delta  = (r_state == ST_DELTA);
    assign o_cmd.commit = commit;

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.delta, o_cmd.commit}))
        else $error("more than one datapath command in a cycle");

    a_accept_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.delta)
        else $error("accepted request not followed by the delta step");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid && !o_in_ready || o_out_valid)
        else $error("commit did not present a result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) && r_out_vld && !i_out_ready |=> (r_state == ST_COMMIT))
        else $error("commit taken while the result register was still full");
`endif

endmodule

[sv/ptra_dp.sv]
module ptra_dp #(
    parameter int NUM_TASKS = ptra_pkg::NUM_TASKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptra_pkg::t_cmd                     i_cmd,
    input  logic                               i_cfg_wr_en,
    input  logic [ptra_pkg::TASK_W-1:0]        i_cfg_wr_data,
    input  logic                               i_op,
    input  logic [ptra_pkg::IN_TDATA_W-1:0]    i_in_data,
    output logic [ptra_pkg::OUT_TDATA_W-1:0]   o_out_data
);

    localparam int TIDX_W = $clog2(NUM_TASKS);
    localparam int TW = ptra_pkg::TASK_W;
    localparam int WW = ptra_pkg::WORD_W;
    localparam int XW = ptra_pkg::WIDE_W;

    // Request fields.
    logic [WW-1:0] raw;
    logic          ov;
    logic [TW-1:0] ot;
    logic          iv;
    logic [TW-1:0] it;

    assign raw = i_in_data[ptra_pkg::IN_RAW_LSB +: WW];
    assign ov  = i_in_data[ptra_pkg::IN_OV_BIT];
    assign ot  = i_in_data[ptra_pkg::IN_OT_LSB +: TW];
    assign iv  = i_in_data[ptra_pkg::IN_IV_BIT];
    assign it  = i_in_data[ptra_pkg::IN_IT_LSB +: TW];

    // Global state.
    logic [TW-1:0] r_idle_id;
    logic [WW-1:0] r_wrap;
    logic [WW-1:0] r_last;
    logic [XW-1:0] r_idle_sum;
    logic [WW-1:0] r_switch_cnt;

    // Latched request.
    logic              r_op;
    logic              r_out_ok;
    logic              r_in_ok;
    logic              r_same;
    logic              r_out_is_idle;
    logic [TIDX_W-1:0] r_out_idx;
    logic [TIDX_W-1:0] r_in_idx;
    logic [XW-1:0]     r_now;

    // Per-task tables and their valid bits.
    logic [XW-1:0] m_start [NUM_TASKS];
    logic [XW-1:0] m_total [NUM_TASKS];
    logic [WW-1:0] m_long  [NUM_TASKS];
    logic [WW-1:0] m_entry [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_so_vld;
    logic [NUM_TASKS-1:0] r_tl_vld;

    // Registered read data.
    logic [XW-1:0] r_start_rd;
    logic [XW-1:0] r_total_rd;
    logic [WW-1:0] r_long_rd;
    logic [WW-1:0] r_entry_rd;
    logic          r_start_hit;
    logic          r_tl_hit;
    logic          r_entry_hit;

    // Outgoing run time.
    logic [XW-1:0] r_delta;
    logic [WW-1:0] r_sat;
    logic [WW-1:0] r_ent_out;

    logic [TIDX_W-1:0] out_idx;
    logic [TIDX_W-1:0] in_idx;
    logic              out_ok;
    logic              in_ok;
    logic              wrap_inc;
    logic [WW-1:0]     wrap_nxt;
    logic [XW-1:0]     start_eff;
    logic [XW-1:0]     total_eff;
    logic [WW-1:0]     long_eff;
    logic [WW-1:0]     entry_eff;
    logic [XW-1:0]     delta;
    logic              apply_out;
    logic              apply_in;
    logic [XW-1:0]     total_new;
    logic [WW-1:0]     long_new;
    logic [WW-1:0]     entry_in_new;
    logic [WW-1:0]     entries_rep;
    logic [XW-1:0]     idle_new;
    logic [WW-1:0]     switch_new;
    logic [TIDX_W-1:0] rd_entry_idx;

    assign out_idx  = TIDX_W'(ot);
    assign in_idx   = TIDX_W'(it);
    assign out_ok   = ov && (32'(ot) < NUM_TASKS);
    assign in_ok    = iv && (32'(it) < NUM_TASKS);
    assign wrap_inc = (raw < r_last);
    assign wrap_nxt = r_wrap + {{(WW-1){1'b0}}, wrap_inc};

    assign start_eff = r_start_hit ? r_start_rd : '0;
    assign total_eff = r_tl_hit    ? r_total_rd : '0;
    assign long_eff  = r_tl_hit    ? r_long_rd  : '0;
    assign entry_eff = r_entry_hit ? r_entry_rd : '0;
    assign delta     = r_now - start_eff;

    assign apply_out    = (r_op == ptra_pkg::OP_SWITCH) && r_out_ok;
    assign apply_in     = (r_op == ptra_pkg::OP_SWITCH) && r_in_ok;
    assign total_new    = total_eff + (apply_out ? r_delta : '0);
    assign long_new     = (apply_out && (r_sat > long_eff)) ? r_sat : long_eff;
    assign entry_in_new = entry_eff + 32'd1;
    assign entries_rep  = (apply_in && r_same) ? entry_in_new : r_ent_out;
    assign idle_new     = (apply_out && r_out_is_idle) ? (r_idle_sum + r_delta) : r_idle_sum;
    assign switch_new   = (r_op == ptra_pkg::OP_SWITCH) ? (r_switch_cnt + 32'd1) : r_switch_cnt;

    // The entry-count table is read for the outgoing task first, then the incoming one.
    assign rd_entry_idx = i_cmd.accept ? out_idx : r_in_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_id    <= '0;
        end else if (i_cfg_wr_en) begin
            r_idle_id    <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap       <= '0;
            r_last       <= '0;
            r_idle_sum   <= '0;
            r_switch_cnt <= '0;
        end else begin
            if (i_cmd.accept && (i_op == ptra_pkg::OP_SWITCH)) begin
                r_wrap <= wrap_nxt;
                r_last <= raw;
            end
            if (i_cmd.commit) begin
                r_idle_sum   <= idle_new;
                r_switch_cnt <= switch_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op          <= i_op;
            r_out_ok      <= out_ok;
            r_in_ok       <= in_ok;
            r_same        <= (ot == it);
            r_out_is_idle <= (ot == r_idle_id);
            r_out_idx     <= out_idx;
            r_in_idx      <= in_idx;
            if (i_op == ptra_pkg::OP_SWITCH) begin
                r_now <= {wrap_nxt, raw};
            end else begin
                r_now <= {r_wrap, r_last};
            end
        end
        if (i_cmd.delta) begin
            r_delta   <= delta;
            r_sat     <= (|delta[XW-1:WW]) ? ptra_pkg::WORD_MAX : delta[WW-1:0];
            r_ent_out <= entry_eff;
        end
    end

    // Valid bits stand in for clearing the tables at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_so_vld <= '0;
            r_tl_vld <= '0;
        end else if (i_cmd.commit) begin
            if (apply_in)  r_so_vld[r_in_idx]  <= 1'b1;
            if (apply_out) r_tl_vld[r_out_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && apply_in) begin
            m_start[r_in_idx] <= r_now;
        end
        if (i_cmd.accept) begin
            r_start_rd  <= m_start[out_idx];
            r_start_hit <= r_so_vld[out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && apply_out) begin
            m_total[r_out_idx] <= total_new;
        end
        if (i_cmd.accept) begin
            r_total_rd <= m_total[out_idx];
            r_tl_hit   <= r_tl_vld[out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && apply_out) begin
            m_long[r_out_idx] <= long_new;
        end
        if (i_cmd.accept) begin
            r_long_rd <= m_long[out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && apply_in) begin
            m_entry[r_in_idx] <= entry_in_new;
        end
        if (i_cmd.accept || i_cmd.delta) begin
            r_entry_rd  <= m_entry[rd_entry_idx];
            r_entry_hit <= r_so_vld[rd_entry_idx];
        end
    end

    // The six result fields fill the result word without gaps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_data[ptra_pkg::OUT_NOW_LSB +: XW]   <= r_now;
            o_out_data[ptra_pkg::OUT_TOTAL_LSB +: XW] <= r_out_ok ? total_new : '0;
            o_out_data[ptra_pkg::OUT_LONG_LSB +: WW]  <= r_out_ok ? long_new : '0;
            o_out_data[ptra_pkg::OUT_ENTRY_LSB +: WW] <= r_out_ok ? entries_rep : '0;
            o_out_data[ptra_pkg::OUT_IDLE_LSB +: XW]  <= idle_new;
            o_out_data[ptra_pkg::OUT_SWTCH_LSB +: WW] <= switch_new;
        end
    end

endmodule

[sv/per_task_runtime_accounting.sv]
// Per-task run time accounting. Each request on the slave stream is either a
// context switch or a record read. A switch carries a raw 32-bit cycle sample,
// which is extended to 64 bits by counting a wrap whenever the sample is below
// the previous one; the outgoing task's run time since its start stamp is added
// to its 64-bit total, its longest burst is raised (saturating at 2^32-1), and
// the run time also feeds the idle total when the outgoing task is the idle
// task set through the configuration port. The incoming task gets a new start
// stamp and one more switch-in count, and every switch bumps the switch
// counter. When the same task leaves and enters, the outgoing update comes
// first. A read returns the record of the task named in the outgoing field and
// changes nothing. Every request gives exactly one result on the master stream.
// A request goes through its steps in order before its result is loaded: on
// acceptance the outgoing task's record is read, the delta step forms the run
// time and reads the incoming task's switch-in count from the same
// single-read-port table, and the commit step writes back and loads the
// result. One request is in flight at a time: a new request is not accepted
// until the last one has been committed, and a full result register holds
// the commit step until the result is taken. The tables need no clearing pass
// after reset: per-entry valid bits make never-written entries read as zero.
module per_task_runtime_accounting #(
    parameter int NUM_TASKS = ptra_pkg::NUM_TASKS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: idle task index.
    input  logic                               i_cfg_wr_en,
    input  logic [ptra_pkg::TASK_W-1:0]        i_cfg_wr_data,
    // Request stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, lowest bit up: raw_cycles[31:0], out_valid[32], out_task[36:33],
    // in_valid[37], in_task[41:38], zero fill[47:42].
    input  logic [ptra_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: operation (0 = context switch, 1 = read record).
    input  logic                               s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, lowest bit up: now_cycles[63:0], task_run_total[127:64],
    // task_longest_burst[159:128], task_entries[191:160], idle_total[255:192],
    // switch_total[287:256].
    output logic [ptra_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    ptra_pkg::t_cmd cmd;

    // Sequencer: accept, delta step, commit, and the result handshake.
    ptra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Counters, per-task tables and the result register.
    ptra_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (s_axis_tuser),
        .i_in_data     (s_axis_tdata),
        .o_out_data    (m_axis_tdata)
    );

endmodule
